[design/lbsl_pkg.sv]
// Package for the load band status LED: color tables, band thresholds and helpers.
`timescale 1ns / 1ps
package lbsl_pkg;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    typedef enum logic [1:0] {
        REG_BRIGHTNESS   = 2'd0,
        REG_TICKS_SAMPLE = 2'd1,
        REG_BLINK_ENABLE = 2'd2
    } t_reg_idx;

    localparam int unsigned NUM_BANDS = 4;
    localparam logic [7:0]  HYST        = 8'd5;
    localparam logic [2:0]  BURST_TICKS = 3'd6;

    localparam t_rgb BAND_RGB [NUM_BANDS] = '{
        '{r: 8'd0,   g: 8'd130, b: 8'd0},
        '{r: 8'd86,  g: 8'd86,  b: 8'd0},
        '{r: 8'd171, g: 8'd43,  b: 8'd0},
        '{r: 8'd255, g: 8'd0,   b: 8'd0}
    };
    localparam logic [7:0] BAND_ENTRY [NUM_BANDS] = '{8'd0, 8'd50, 8'd75, 8'd90};
    localparam t_rgb MAGENTA = '{r: 8'd186, g: 8'd0, b: 8'd186};
    localparam t_rgb BLACK   = '{r: 8'd0,   g: 8'd0, b: 8'd0};

    localparam logic [7:0] RST_BRIGHTNESS   = 8'd32;
    localparam logic [7:0] RST_TICKS_SAMPLE = 8'd10;

    // Hysteresis classifier: climb while at or above next entry, then fall while more than HYST below own entry.
    function automatic logic [1:0] classify(input logic [1:0] band, input logic [6:0] load);
        logic [1:0] b;
        logic [7:0] ld;
        b  = band;
        ld = {1'b0, load};
        for (int i = 0; i < NUM_BANDS - 1; i++) begin
            if (b != 2'd3 && ld >= BAND_ENTRY[b + 2'd1]) begin
                b = b + 2'd1;
            end
        end
        for (int i = 0; i < NUM_BANDS - 1; i++) begin
            if (b != 2'd0 && (ld + HYST) < BAND_ENTRY[b]) begin
                b = b - 2'd1;
            end
        end
        return b;
    endfunction

    // v * br / 255, exact over every product of two 8-bit operands.
    function automatic logic [7:0] scale_ch(input logic [7:0] v, input logic [7:0] br);
        logic [15:0] p;
        logic [16:0] q;
        p = v * br;
        q = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
        return q[15:8];
    endfunction

endpackage

[design/load_band_status_led.sv]
// Load band status LED: per-tick blink burst, load band classifier and scaled color output.
// The result of an accepted request is registered in the output register in the cycle after it is accepted.
// Throughput: one request per cycle unless stalled; a new request is taken while the result is taken.
// The input stalls only while a result is held and the output side stalls.
// Reset (synchronous, active low): green band, no burst, divider and last color cleared,
// brightness 32, sample period 10, blink enabled, output register empty.
`timescale 1ns / 1ps
module load_band_status_led (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_alloc_failure,
    input  logic       i_sample_ok,
    input  logic [6:0] i_load_percent,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_write_strobe,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    output logic [1:0] o_band_index,
    output logic       o_blinking,
    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic [3:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);
    import lbsl_pkg::*;

    logic [7:0] r_brightness;
    logic [7:0] r_ticks_sample;
    logic       r_blink_en;

    logic [1:0] r_band,  n_band;
    logic [2:0] r_blink_count, n_blink_count;
    logic [7:0] r_div,   n_div;
    t_rgb       r_last_color, n_last_color;
    logic       r_color_written, n_color_written;

    logic       r_out_valid;
    logic       r_strobe, n_strobe;
    t_rgb       r_rgb, n_rgb;
    logic [1:0] r_band_out;
    logic       r_blinking, n_blinking;

    logic       in_acc;
    logic       cfg_wr;
    t_reg_idx   cfg_idx;
    logic [2:0] bc;
    logic [8:0] div_inc;
    t_rgb       color;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_idx  = t_reg_idx'(paddr[3:2]);

    always_comb begin
        unique case (cfg_idx)
            REG_BRIGHTNESS:   prdata = {24'd0, r_brightness};
            REG_TICKS_SAMPLE: prdata = {24'd0, r_ticks_sample};
            REG_BLINK_ENABLE: prdata = {31'd0, r_blink_en};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness   <= RST_BRIGHTNESS;
            r_ticks_sample <= RST_TICKS_SAMPLE;
            r_blink_en     <= 1'b1;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_BRIGHTNESS:   r_brightness   <= pwdata[7:0];
                REG_TICKS_SAMPLE: r_ticks_sample <= pwdata[7:0];
                REG_BLINK_ENABLE: r_blink_en     <= pwdata[0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        n_band          = r_band;
        n_div           = r_div;
        n_blinking      = 1'b0;
        bc              = (i_alloc_failure && r_blink_en) ? BURST_TICKS : r_blink_count;
        div_inc         = {1'b0, r_div} + 9'd1;
        n_blink_count   = bc;
        if (bc != 3'd0) begin
            color         = bc[0] ? MAGENTA : BLACK;
            n_blink_count = bc - 3'd1;
            n_blinking    = 1'b1;
        end else begin
            if (div_inc >= {1'b0, r_ticks_sample}) begin
                n_div = 8'd0;
                if (i_sample_ok) begin
                    n_band = classify(r_band, i_load_percent);
                end
            end else begin
                n_div = div_inc[7:0];
            end
            color = BAND_RGB[n_band];
        end
        n_strobe        = !r_color_written || (color != r_last_color);
        n_last_color    = n_strobe ? color : r_last_color;
        n_color_written = r_color_written || n_strobe;
        n_rgb.r         = scale_ch(color.r, r_brightness);
        n_rgb.g         = scale_ch(color.g, r_brightness);
        n_rgb.b         = scale_ch(color.b, r_brightness);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band          <= 2'd0;
            r_blink_count   <= 3'd0;
            r_div           <= 8'd0;
            r_last_color    <= BLACK;
            r_color_written <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (in_acc) begin
                r_band          <= n_band;
                r_blink_count   <= n_blink_count;
                r_div           <= n_div;
                r_last_color    <= n_last_color;
                r_color_written <= n_color_written;
                r_out_valid     <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid     <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_strobe   <= n_strobe;
            r_rgb      <= n_rgb;
            r_band_out <= n_band;
            r_blinking <= n_blinking;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_write_strobe = r_strobe;
    assign o_red          = r_rgb.r;
    assign o_green        = r_rgb.g;
    assign o_blue         = r_rgb.b;
    assign o_band_index   = r_band_out;
    assign o_blinking     = r_blinking;

    a_blink_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blink_count <= BURST_TICKS)
        else $error("blink count out of range");

    a_div_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (r_blink_count != 3'd0) |=> $stable(r_div) && $stable(r_band))
        else $error("divider or band moved during a burst");

    a_unwritten_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_color_written |-> (r_last_color == BLACK))
        else $error("last color set without a write");

    a_first_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !r_color_written |=> r_strobe && r_color_written)
        else $error("first request raised no strobe");

endmodule

[tb/sv/tb.sv]
// Testbench for load_band_status_led: directed and random ticks checked against a local predictor.
`timescale 1ns / 1ps
module tb;
    import lbsl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HYST_PCT    = 5;
    localparam int BURST_LEN   = 6;
    localparam int BAND_FLOOR [4] = '{0, 50, 75, 90};
    localparam t_rgb LED_RGB [4] = '{24'h008200, 24'h565600, 24'hAB2B00, 24'hFF0000};
    localparam t_rgb MAGENTA_RGB = 24'hBA00BA;
    localparam t_rgb OFF_RGB     = 24'h000000;

    typedef struct packed {
        logic       fail;
        logic       ok;
        logic [6:0] load;
    } t_tick;

    typedef struct packed {
        logic       strobe;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [1:0] band;
        logic       blink;
    } t_led;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_alloc_failure = 1'b0;
    logic        i_sample_ok = 1'b0;
    logic [6:0]  i_load_percent = 7'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_write_strobe;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [1:0]  o_band_index;
    logic        o_blinking;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state and register copies
    int   band_now = 0;
    int   burst_left = 0;
    int   divider = 0;
    t_rgb last_rgb = OFF_RGB;
    bit   rgb_written = 1'b0;
    int   cfg_bright = 32;
    int   cfg_period = 10;
    bit   cfg_blink_en = 1'b1;

    t_tick tick_queue[$];
    t_led  led_expect[$];
    bit    tick_taken = 1'b0;
    int    idle_pct = 29;
    int    fail_cnt = 0;
    int    cycle_cnt = 0;

    load_band_status_led uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_alloc_failure (i_alloc_failure),
        .i_sample_ok     (i_sample_ok),
        .i_load_percent  (i_load_percent),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_write_strobe  (o_write_strobe),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue),
        .o_band_index    (o_band_index),
        .o_blinking      (o_blinking),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic logic [7:0] dim(input logic [7:0] v);
        return 8'((int'(v) * cfg_bright) / 255);
    endfunction

    // one tick: blink burst, sample divider, band hysteresis, strobe on color change
    function automatic t_led led_tick(input t_tick t);
        t_led res;
        t_rgb rgb;
        int   ld;
        res = '0;
        ld  = t.load;
        if (t.fail && cfg_blink_en) begin
            burst_left = BURST_LEN;
        end
        if (burst_left != 0) begin
            rgb = (burst_left % 2 == 1) ? MAGENTA_RGB : OFF_RGB;
            burst_left--;
            res.blink = 1'b1;
        end else begin
            if (divider + 1 >= cfg_period) begin
                divider = 0;
                if (t.ok) begin
                    while (band_now < 3 && ld >= BAND_FLOOR[band_now + 1]) band_now++;
                    while (band_now > 0 && ld + HYST_PCT < BAND_FLOOR[band_now]) band_now--;
                end
            end else begin
                divider++;
            end
            rgb = LED_RGB[band_now];
        end
        res.strobe = !rgb_written || rgb != last_rgb;
        if (res.strobe) begin
            last_rgb    = rgb;
            rgb_written = 1'b1;
        end
        res.r    = dim(rgb.r);
        res.g    = dim(rgb.g);
        res.b    = dim(rgb.b);
        res.band = 2'(band_now);
        return res;
    endfunction

    function automatic t_tick rand_tick();
        t_tick t;
        int    pick;
        t.fail = ($urandom_range(99) < 5);
        t.ok   = ($urandom_range(99) < 90);
        pick   = $urandom_range(99);
        if (pick < 65) begin
            t.load = 7'(BAND_FLOOR[$urandom_range(3, 1)] + $urandom_range(12) - 8);
        end else if (pick < 85) begin
            t.load = 7'($urandom_range(100));
        end else begin
            t.load = 7'($urandom_range(127));
        end
        return t;
    endfunction

    task automatic push_tick(input bit fail, input bit ok, input int load);
        t_tick t;
        t.fail = fail;
        t.ok   = ok;
        t.load = 7'(load);
        tick_queue.push_back(t);
    endtask

    task automatic drain();
        do begin
            @(posedge i_clk);
            #1;
        end while (tick_queue.size() != 0 || i_in_valid || led_expect.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic reg_write(input t_reg_idx idx, input logic [7:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_BRIGHTNESS:   cfg_bright   = val;
            REG_TICKS_SAMPLE: cfg_period   = val;
            REG_BLINK_ENABLE: cfg_blink_en = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic setup(input int br, input int period, input int blink);
        reg_write(REG_BRIGHTNESS, 8'(br));
        reg_write(REG_TICKS_SAMPLE, 8'(period));
        reg_write(REG_BLINK_ENABLE, 8'(blink));
    endtask

    task automatic soak(input int n);
        repeat (n) tick_queue.push_back(rand_tick());
        drain();
    endtask

    // request driver
    always @(negedge i_clk) begin
        t_tick t;
        if (i_rst_n) begin
            if (!i_in_valid || tick_taken) begin
                if (tick_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    t = tick_queue.pop_front();
                    i_in_valid      <= 1'b1;
                    i_alloc_failure <= t.fail;
                    i_sample_ok     <= t.ok;
                    i_load_percent  <= t.load;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_led  got;
        t_led  want;
        t_tick req;
        if (i_rst_n) begin
            tick_taken <= i_in_valid && !o_in_stall;
            if (o_out_valid && !i_out_stall) begin
                got.strobe = o_write_strobe;
                got.r      = o_red;
                got.g      = o_green;
                got.b      = o_blue;
                got.band   = o_band_index;
                got.blink  = o_blinking;
                if (led_expect.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) $display("unexpected result: %h", got);
                end else begin
                    want = led_expect.pop_front();
                    if (got !== want) begin
                        fail_cnt++;
                        if (fail_cnt <= 10) begin
                            $display("mismatch exp: strobe %b rgb %h %h %h band %0d blink %b",
                                     want.strobe, want.r, want.g, want.b, want.band, want.blink);
                            $display("         got: strobe %b rgb %h %h %h band %0d blink %b",
                                     got.strobe, got.r, got.g, got.b, got.band, got.blink);
                        end
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                req.fail = i_alloc_failure;
                req.ok   = i_sample_ok;
                req.load = i_load_percent;
                led_expect.push_back(led_tick(req));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[load_band_status_led] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: first write, burst, restart inside a burst
        push_tick(0, 1, 0);
        push_tick(1, 1, 127);
        push_tick(0, 1, 0);
        push_tick(1, 1, 0);
        repeat (6) push_tick(0, 1, 0);
        drain();

        // every tick samples; band climbs and falls through hysteresis
        setup(255, 1, 0);
        push_tick(0, 1, 50);
        push_tick(0, 1, 75);
        push_tick(0, 1, 90);
        push_tick(0, 1, 85);
        push_tick(0, 1, 84);
        push_tick(0, 1, 70);
        push_tick(0, 1, 69);
        push_tick(0, 1, 45);
        push_tick(0, 1, 44);
        push_tick(1, 1, 127);
        push_tick(0, 1, 0);
        push_tick(0, 0, 100);
        drain();

        setup(255, 0, 1);
        soak(200);
        setup(0, 1, 1);
        soak(150);
        idle_pct = 0;
        setup(128, 2, 1);
        soak(200);
        idle_pct = 29;
        setup(200, 255, 1);
        soak(150);
        // period lowered below the running divider
        setup(77, 3, 0);
        soak(200);
        repeat (4) begin
            setup($urandom_range(255), $urandom_range(8), $urandom_range(1));
            soak(180);
        end

        repeat (4) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("[load_band_status_led] OK");
        end else begin
            $display("[load_band_status_led] ERROR");
        end
        $finish;
    end
endmodule

[load_band_status_led.f]
design/lbsl_pkg.sv
design/load_band_status_led.sv
tb/sv/tb.sv
